FILE: design/pee_pkg.sv
// Shared types and constants of the postfix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

   // Width of the result value port
   localparam int VALUE_BITS = 32;

   // Expression characters
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // capture the input word
      logic push_digit;  // push the digit value (or flag overflow)
      logic drop_all;    // too few operands: empty the stack, flag underflow
      logic read_pair;   // read the two top operands
      logic start_op;    // pop two; push the sum, difference or a divide-by-zero zero, or start the unit
      logic push_unit;   // push the multiply or divide result
      logic read_top;    // read the final top of stack
      logic emit;        // load the result word, clear the stack
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_digit;
      logic lt2;
      logic last;
      logic long_op;
      logic unit_busy;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/pee_ctrl.sv
// Controller state machine of the postfix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

module pee_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire pee_pkg::stat_type stat,
   output pee_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_OPRD,
      S_CALC,
      S_TOPRD,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type after_item;

   // Where to go once the character is done
   assign after_item = stat.last ? S_TOPRD : S_IDLE;

   // Sequence one word through the datapath
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_digit) begin
               cmd.push_digit = 1'b1;
               state_in       = after_item;
            end else if (stat.lt2) begin
               cmd.drop_all = 1'b1;
               state_in     = after_item;
            end else begin
               cmd.read_pair = 1'b1;
               state_in      = S_OPRD;
            end
         end
         S_OPRD: begin
            cmd.start_op = 1'b1;
            state_in     = stat.long_op ? S_CALC : after_item;
         end
         S_CALC: begin
            if (!stat.unit_busy) begin
               cmd.push_unit = 1'b1;
               state_in      = after_item;
            end
         end
         S_TOPRD: begin
            cmd.read_top = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            // Wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: design/pee_dpath.sv
// Datapath of the postfix expression evaluator: operand stack, count, error and arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

module pee_dpath #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [7:0]                            req_ch,
   input  wire logic                                  req_last,
   input  wire pee_pkg::cmd_type                      cmd,
   output pee_pkg::stat_type                          stat,
   output logic signed [pee_pkg::VALUE_BITS-1:0]      rsp_value,
   output logic [1:0]                                 rsp_status
);

   localparam int W  = VALUE_WIDTH;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int NW = $clog2(VALUE_WIDTH + 1);
   localparam int OW = pee_pkg::VALUE_BITS;

   // Operand stack and bookkeeping
   logic [W-1:0]        stack_ff [STACK_DEPTH];
   logic [CW-1:0]       count_ff, count_in;
   pee_pkg::status_type err_ff, err_in;
   logic [7:0]          ch_ff;
   logic                last_ff;
   logic [W-1:0]        rd_a_ff, rd_b_ff;

   // Shared multiply / divide unit
   logic [W-1:0]  a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          op_div_ff, op_div_in, negq_ff, negq_in;

   // Result word
   logic [OW-1:0] value_ff;
   logic [1:0]    status_ff;

   logic [CW-1:0] count_m1, count_m2;
   logic          is_digit, is_plus, is_minus, is_star, is_slash;
   logic          full, r_zero, neg_l, neg_r;
   logic [W-1:0]  mag_l, mag_r, digit_val, sum_val, diff_val, unit_res;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [W-1:0]  wr_data;
   logic          flag_req;
   pee_pkg::status_type flag_code;
   logic [W:0]    div_shift, div_diff;
   logic          div_ge;

   assign count_m1  = count_ff - CW'(1);
   assign count_m2  = count_ff - CW'(2);
   assign is_digit  = (ch_ff >= pee_pkg::CH_ZERO) && (ch_ff <= pee_pkg::CH_NINE);
   assign is_plus   = (ch_ff == pee_pkg::CH_PLUS);
   assign is_minus  = (ch_ff == pee_pkg::CH_MINUS);
   assign is_star   = (ch_ff == pee_pkg::CH_STAR);
   assign is_slash  = (ch_ff == pee_pkg::CH_SLASH);
   assign full      = (count_ff == CW'(STACK_DEPTH));
   assign r_zero    = (rd_a_ff == '0);
   assign neg_l     = rd_b_ff[W-1];
   assign neg_r     = rd_a_ff[W-1];
   assign mag_l     = neg_l ? W'(-rd_b_ff) : rd_b_ff;
   assign mag_r     = neg_r ? W'(-rd_a_ff) : rd_a_ff;
   assign digit_val = W'(ch_ff - pee_pkg::CH_ZERO);
   assign sum_val   = rd_b_ff + rd_a_ff;
   assign diff_val  = rd_b_ff - rd_a_ff;
   assign unit_res  = op_div_ff ? (negq_ff ? W'(-a_ff) : a_ff) : acc_ff;

   assign stat.is_digit  = is_digit;
   assign stat.lt2       = (count_ff < CW'(2));
   assign stat.last      = last_ff;
   assign stat.long_op   = is_star || (is_slash && !r_zero);
   assign stat.unit_busy = (cnt_ff != '0);

   // Capture the input word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff   <= req_ch;
         last_ff <= req_last;
      end
   end

   // Select the stack write
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = digit_val;
      if (cmd.push_digit && !full) begin
         wr_en = 1'b1;
      end else if (cmd.start_op && (is_plus || is_minus || (is_slash && r_zero))) begin
         wr_en   = 1'b1;
         wr_addr = count_m2[AW-1:0];
         wr_data = is_plus ? sum_val : (is_minus ? diff_val : '0);
      end else if (cmd.push_unit) begin
         wr_en   = 1'b1;
         wr_data = unit_res;
      end
   end

   // Write the stack
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
   end

   // Read the operands or the top, registered
   always_ff @(posedge clock) begin
      if (cmd.read_pair || cmd.read_top) begin
         rd_a_ff <= stack_ff[count_m1[AW-1:0]];
      end
      if (cmd.read_pair) begin
         rd_b_ff <= stack_ff[count_m2[AW-1:0]];
      end
   end

   // Raise an error, first one wins
   always_comb begin
      flag_req  = 1'b0;
      flag_code = pee_pkg::ST_OK;
      if (cmd.push_digit && full) begin
         flag_req  = 1'b1;
         flag_code = pee_pkg::ST_OVER;
      end else if (cmd.drop_all || (cmd.read_top && count_ff == '0)) begin
         flag_req  = 1'b1;
         flag_code = pee_pkg::ST_UNDER;
      end else if (cmd.start_op && is_slash && r_zero) begin
         flag_req  = 1'b1;
         flag_code = pee_pkg::ST_DIVZ;
      end
   end

   // Advance the count and the error
   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (flag_req && err_ff == pee_pkg::ST_OK) begin
         err_in = flag_code;
      end
      priority if (cmd.emit) begin
         count_in = '0;
         err_in   = pee_pkg::ST_OK;
      end else if (cmd.push_digit && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.drop_all) begin
         count_in = '0;
      end else if (cmd.start_op) begin
         count_in = (is_plus || is_minus || (is_slash && r_zero)) ? count_m1 : count_m2;
      end else if (cmd.push_unit) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= pee_pkg::ST_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // One restoring divide step on the remainder
   assign div_shift = {acc_ff, a_ff[W-1]};
   assign div_diff  = div_shift - {1'b0, b_ff};
   assign div_ge    = !div_diff[W];

   // Load or step the multiply / divide unit
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      op_div_in = op_div_ff;
      negq_in   = negq_ff;
      if (cmd.start_op && (is_star || (is_slash && !r_zero))) begin
         a_in      = is_star ? rd_b_ff : mag_l;
         b_in      = is_star ? rd_a_ff : mag_r;
         acc_in    = '0;
         cnt_in    = NW'(W);
         op_div_in = is_slash;
         negq_in   = neg_l ^ neg_r;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - NW'(1);
         if (op_div_ff) begin
            acc_in = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
            a_in   = {a_ff[W-2:0], div_ge};
         end else begin
            acc_in = b_ff[0] ? (acc_ff + a_ff) : acc_ff;
            a_in   = {a_ff[W-2:0], 1'b0};
            b_in   = {1'b0, b_ff[W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      op_div_ff <= op_div_in;
      negq_ff   <= negq_in;
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         value_ff  <= (err_ff == pee_pkg::ST_OK) ? OW'(rd_a_ff) : '0;
         status_ff <= err_ff;
      end
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

FILE: design/postfix_expression_evaluator_unit.sv
// Top level of the postfix expression evaluator.
//
//   channel  ports                          direction  word
//   req      req_valid req_stall            in         req_ch[7:0], req_last
//   rsp      rsp_valid rsp_stall            out        rsp_value[31:0] signed, rsp_status[1:0]
//
// A digit, or an operator short of operands, is done once decoded; add, subtract, divide by
// zero and any other character also read the two top operands; multiply and divide then run
// on one shared shift-add / restoring divide unit, one bit per cycle.
// A word marked last then reads the top of stack and loads the result register.
// Reset is synchronous and clears control, stack count and error, not the stack entries.
// A waiting result lets the next word in; a second result stalls input until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_ch,
   input  wire logic                              req_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [pee_pkg::VALUE_BITS-1:0]  rsp_value,
   output logic [1:0]                             rsp_status
);

   pee_pkg::cmd_type  cmd;
   pee_pkg::stat_type stat;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire
